/* design/sereg_pkg.sv */
// Shared types and constants for the system engine register block.
package sereg_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [3:0] {
        KIND_IDX_WR    = 4'd0,
        KIND_REG_RD    = 4'd1,
        KIND_REG_WR    = 4'd2,
        KIND_MEM_WR    = 4'd3,
        KIND_CNT_RESET = 4'd4,
        KIND_CNT_RD    = 4'd5,
        KIND_CLK_TICK  = 4'd6,
        KIND_PCM_DATA  = 4'd7,
        KIND_PCM_CTL   = 4'd8,
        KIND_PCM_STAT  = 4'd9,
        KIND_PCM_CNT   = 4'd10,
        KIND_PCM_TICK  = 4'd11,
        KIND_PAUSE_WR  = 4'd12,
        KIND_PAUSE_BTN = 4'd13
    } kind_t;

    // Register file geometry.
    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_IDX_W = 4;

    // Special register file entries.
    localparam logic [REG_IDX_W-1:0] SWITCH_REG   = 4'd5;
    localparam logic [REG_IDX_W-1:0] CPU_REG      = 4'd6;
    localparam logic [REG_IDX_W-1:0] SHIFT_LO_REG = 4'd14;
    localparam logic [REG_IDX_W-1:0] SHIFT_HI_REG = 4'd15;

    // Bit positions and fixed values.
    localparam int unsigned CPU_SEL_BIT = 5;
    localparam int unsigned MUTE_BIT    = 1;
    localparam logic [7:0] CPU_REG_RESET = 8'h20;
    localparam logic [7:0] SWITCH_ON_VAL = 8'h40;
    localparam logic [7:0] LATCH_RESET   = 8'h80;

    // Field widths.
    localparam int unsigned PRESCALE_W = 5;
    localparam int unsigned COUNTER_W  = 16;
    localparam int unsigned CTRL_W     = 5;
    localparam int unsigned TICK_W     = 2;

    // Fields of one input item, apart from the kind.
    typedef struct packed {
        logic       pause_button;
        logic       comparator;
        logic       firmware_switch;
        logic       byte_select;
        logic [7:0] data;
    } item_t;

    // Fields of one result item.
    typedef struct packed {
        logic              cpu_wait;
        logic              turbo_led;
        logic              pause_led;
        logic [CTRL_W-1:0] pcm_lines;
        logic [7:0]        dac_value;
        logic              dac_strobe;
        logic              main_cpu_active;
        logic [7:0]        read_data;
    } result_t;

endpackage

/* design/sereg_core.sv */
// State registers and per-item update logic of the system engine register block.
module sereg_core #(
    parameter int unsigned COUNTER_DIVIDE = 28
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  sereg_pkg::kind_t    item_kind,
    input  sereg_pkg::item_t    item,
    output sereg_pkg::result_t  result
);

    localparam int unsigned PW = sereg_pkg::PRESCALE_W;
    localparam int unsigned CW = sereg_pkg::COUNTER_W;
    localparam logic [PW:0] DIVIDE = (PW+1)'(COUNTER_DIVIDE);

    logic [7:0]                       reg_file_reg [sereg_pkg::REG_COUNT];
    logic [7:0]                       reg_index_reg;
    logic [PW-1:0]                    prescaler_reg;
    logic [CW-1:0]                    counter_reg;
    logic [7:0]                       latch_reg;
    logic [sereg_pkg::CTRL_W-1:0]     ctrl_reg;
    logic [sereg_pkg::TICK_W-1:0]     tick_reg;
    logic                             pending_reg;
    logic                             halt_reg;
    logic [1:0]                       led_reg;
    logic                             wait_reg;

    logic [7:0]                       reg_index_next;
    logic [PW-1:0]                    prescaler_next;
    logic [CW-1:0]                    counter_next;
    logic [7:0]                       latch_next;
    logic [sereg_pkg::CTRL_W-1:0]     ctrl_next;
    logic [sereg_pkg::TICK_W-1:0]     tick_next;
    logic                             pending_next;
    logic                             halt_next;
    logic [1:0]                       led_next;
    logic                             wait_next;

    logic                             rf_we;
    logic [sereg_pkg::REG_IDX_W-1:0]  rf_waddr;
    logic                             shift_we;
    logic [sereg_pkg::REG_IDX_W-1:0]  sel;
    logic [7:0]                       cpu_reg_next;
    logic [PW:0]                      prescaler_inc;
    logic [7:0]                       read_data;
    logic                             strobe;
    logic [7:0]                       dac_value;

    assign sel           = reg_index_reg[sereg_pkg::REG_IDX_W-1:0];
    assign prescaler_inc = {1'b0, prescaler_reg} + (PW+1)'(1);

    // Next state and read data for the item at the input.
    always_comb begin
        reg_index_next = reg_index_reg;
        prescaler_next = prescaler_reg;
        counter_next   = counter_reg;
        latch_next     = latch_reg;
        ctrl_next      = ctrl_reg;
        tick_next      = tick_reg;
        pending_next   = pending_reg;
        halt_next      = halt_reg;
        led_next       = led_reg;
        wait_next      = wait_reg;
        rf_we          = 1'b0;
        rf_waddr       = sel;
        shift_we       = 1'b0;
        read_data      = '0;
        strobe         = 1'b0;
        dac_value      = '0;
        unique case (item_kind)
            sereg_pkg::KIND_IDX_WR: begin
                reg_index_next = item.data;
            end
            sereg_pkg::KIND_REG_RD: begin
                if (sel == sereg_pkg::SWITCH_REG) begin
                    read_data = item.firmware_switch ? sereg_pkg::SWITCH_ON_VAL : 8'h00;
                end else begin
                    read_data = reg_file_reg[sel];
                end
            end
            sereg_pkg::KIND_REG_WR: begin
                rf_we = 1'b1;
            end
            sereg_pkg::KIND_MEM_WR: begin
                shift_we = 1'b1;
            end
            sereg_pkg::KIND_CNT_RESET: begin
                prescaler_next = '0;
                counter_next   = '0;
            end
            sereg_pkg::KIND_CNT_RD: begin
                read_data = item.byte_select ? counter_reg[15:8] : counter_reg[7:0];
            end
            sereg_pkg::KIND_CLK_TICK: begin
                if (prescaler_inc >= DIVIDE) begin
                    prescaler_next = '0;
                    counter_next   = counter_reg + CW'(1);
                end else begin
                    prescaler_next = prescaler_inc[PW-1:0];
                end
            end
            sereg_pkg::KIND_PCM_DATA: begin
                latch_next = item.data;
                if (!ctrl_reg[sereg_pkg::MUTE_BIT]) begin
                    tick_next    = '0;
                    pending_next = 1'b1;
                end
            end
            sereg_pkg::KIND_PCM_CTL: begin
                ctrl_next = item.data[sereg_pkg::CTRL_W-1:0];
            end
            sereg_pkg::KIND_PCM_STAT: begin
                read_data = {item.comparator, 2'b00, ctrl_reg};
            end
            sereg_pkg::KIND_PCM_CNT: begin
                read_data = {6'b0, tick_reg};
            end
            sereg_pkg::KIND_PCM_TICK: begin
                tick_next = tick_reg + sereg_pkg::TICK_W'(1);
                if (pending_reg) begin
                    strobe       = 1'b1;
                    dac_value    = latch_reg;
                    pending_next = 1'b0;
                end
            end
            sereg_pkg::KIND_PAUSE_WR: begin
                led_next  = {item.data[7], item.data[0]};
                halt_next = item.data[1];
            end
            sereg_pkg::KIND_PAUSE_BTN: begin
                if (halt_reg && reg_file_reg[sereg_pkg::CPU_REG][sereg_pkg::CPU_SEL_BIT]) begin
                    wait_next = item.pause_button;
                end
            end
            default: begin
            end
        endcase
    end

    // Entry 6 as it stands after this item, for the CPU select output.
    always_comb begin
        cpu_reg_next = reg_file_reg[sereg_pkg::CPU_REG];
        if (rf_we && rf_waddr == sereg_pkg::CPU_REG) begin
            cpu_reg_next = item.data;
        end
    end

    // Result fields reflect the state after the item.
    always_comb begin
        result                 = '0;
        result.read_data       = read_data;
        result.main_cpu_active = cpu_reg_next[sereg_pkg::CPU_SEL_BIT];
        result.dac_strobe      = strobe;
        result.dac_value       = dac_value;
        result.pcm_lines       = ctrl_next;
        result.pause_led       = led_next[0];
        result.turbo_led       = led_next[1];
        result.cpu_wait        = wait_next;
    end

    // State update on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sereg_pkg::REG_COUNT; i++) begin
                reg_file_reg[i] <= (i == int'(sereg_pkg::CPU_REG)) ?
                                   sereg_pkg::CPU_REG_RESET : 8'h00;
            end
            reg_index_reg <= '0;
            prescaler_reg <= '0;
            counter_reg   <= '0;
            latch_reg     <= sereg_pkg::LATCH_RESET;
            ctrl_reg      <= '0;
            tick_reg      <= '0;
            pending_reg   <= 1'b0;
            halt_reg      <= 1'b0;
            led_reg       <= '0;
            wait_reg      <= 1'b0;
        end else if (item_valid) begin
            if (rf_we) begin
                reg_file_reg[rf_waddr] <= item.data;
            end
            if (shift_we) begin
                reg_file_reg[sereg_pkg::SHIFT_LO_REG] <= reg_file_reg[sereg_pkg::SHIFT_HI_REG];
                reg_file_reg[sereg_pkg::SHIFT_HI_REG] <= item.data;
            end
            reg_index_reg <= reg_index_next;
            prescaler_reg <= prescaler_next;
            counter_reg   <= counter_next;
            latch_reg     <= latch_next;
            ctrl_reg      <= ctrl_next;
            tick_reg      <= tick_next;
            pending_reg   <= pending_next;
            halt_reg      <= halt_next;
            led_reg       <= led_next;
            wait_reg      <= wait_next;
        end
    end

endmodule

/* design/system_engine_register_block.sv */
// Top level of the system engine register block with its stream ports.
//
// Each input item is one bus access or clock tick, chosen by the kind on
// s_tuser, and produces exactly one result item. The block takes one item
// per clock cycle: the state update and the result are computed combinationally
// and the result is held in an output register, so an item is
// accepted whenever that register is empty or being drained in the same
// cycle, and its result appears on the master side in the cycle after
// acceptance. The free counter advances once every COUNTER_DIVIDE clock
// tick items (1 to 32).
module system_engine_register_block #(
    parameter int unsigned COUNTER_DIVIDE = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // data[7:0], byte_select[8], firmware_switch[9], comparator[10],
    // pause_button[11], zero[15:12]
    input  logic [15:0] s_tdata,
    // kind[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], main_cpu_active[8], dac_strobe[9], dac_value[17:10],
    // pcm_lines[22:18], pause_led[23], turbo_led[24], cpu_wait[25], zero[31:26]
    output logic [31:0] m_tdata
);

    logic                 accept;
    sereg_pkg::item_t     item;
    sereg_pkg::result_t   result;
    logic                 out_valid_reg;
    sereg_pkg::result_t   out_data_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign item     = s_tdata[11:0];

    sereg_core #(
        .COUNTER_DIVIDE (COUNTER_DIVIDE)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item_kind  (sereg_pkg::kind_t'(s_tuser)),
        .item       (item),
        .result     (result)
    );

    // Output register: loads on accept, empties when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg};

endmodule

/* tb/system_engine_register_block_tb.sv */
// Self-checking testbench for the system engine register block.
`timescale 1ns / 100ps

module system_engine_register_block_tb;

    localparam int COUNTER_DIVIDE   = 28;
    localparam int ITEM_TARGET      = 850;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 4;

    // Kind codes the package leaves unused; the block must ignore them.
    localparam logic [3:0] KIND_SPARE_LO = 4'd14;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;

    // Receiver stall styles.
    localparam int READY_ALWAYS  = 0;
    localparam int READY_RANDOM  = 1;
    localparam int READY_PATTERN = 2;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predicted engine state.
    logic [7:0]  shadow_regs [sereg_pkg::REG_COUNT];
    logic [7:0]  shadow_index;
    logic [sereg_pkg::PRESCALE_W-1:0] shadow_prescale;
    logic [sereg_pkg::COUNTER_W-1:0]  shadow_counter;
    logic [7:0]  shadow_latch;
    logic [sereg_pkg::CTRL_W-1:0] shadow_pcm_ctl;
    logic [sereg_pkg::TICK_W-1:0] shadow_pcm_ticks;
    logic        shadow_dac_due;
    logic        shadow_halt_en;
    logic [1:0]  shadow_leds;
    logic        shadow_wait;

    sereg_pkg::result_t engine_results_due [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          idle_cycles    = 0;

    // Sender and receiver pacing controls.
    bit          gaps_on     = 1'b1;
    int          burst_left  = 0;
    int          ready_style = READY_PATTERN;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    logic [15:0] ready_pattern = 16'hffff;
    int          pattern_pos   = 0;

    sereg_pkg::result_t got_result;
    sereg_pkg::result_t want_result;

    system_engine_register_block #(
        .COUNTER_DIVIDE(COUNTER_DIVIDE)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Put the predicted state into its reset condition.
    task automatic reset_engine_model();
        for (int i = 0; i < sereg_pkg::REG_COUNT; i++) begin
            shadow_regs[i] = 8'h00;
        end
        shadow_regs[sereg_pkg::CPU_REG] = sereg_pkg::CPU_REG_RESET;
        shadow_index     = '0;
        shadow_prescale  = '0;
        shadow_counter   = '0;
        shadow_latch     = sereg_pkg::LATCH_RESET;
        shadow_pcm_ctl   = '0;
        shadow_pcm_ticks = '0;
        shadow_dac_due   = 1'b0;
        shadow_halt_en   = 1'b0;
        shadow_leds      = '0;
        shadow_wait      = 1'b0;
    endtask

    // Apply one item to the predicted state and work out its result.
    task automatic predict_engine_result(input logic [3:0] kind_code,
                                         input sereg_pkg::item_t it,
                                         output sereg_pkg::result_t res);
        logic [3:0] sel;
        sel = shadow_index[3:0];
        res = '0;
        case (kind_code)
            sereg_pkg::KIND_IDX_WR: begin
                shadow_index = it.data;
            end
            sereg_pkg::KIND_REG_RD: begin
                if (sel == sereg_pkg::SWITCH_REG) begin
                    res.read_data = it.firmware_switch ? sereg_pkg::SWITCH_ON_VAL : 8'h00;
                end else begin
                    res.read_data = shadow_regs[sel];
                end
            end
            sereg_pkg::KIND_REG_WR: begin
                shadow_regs[sel] = it.data;
            end
            sereg_pkg::KIND_MEM_WR: begin
                shadow_regs[sereg_pkg::SHIFT_LO_REG] = shadow_regs[sereg_pkg::SHIFT_HI_REG];
                shadow_regs[sereg_pkg::SHIFT_HI_REG] = it.data;
            end
            sereg_pkg::KIND_CNT_RESET: begin
                shadow_prescale = '0;
                shadow_counter  = '0;
            end
            sereg_pkg::KIND_CNT_RD: begin
                res.read_data = it.byte_select ? shadow_counter[15:8] : shadow_counter[7:0];
            end
            sereg_pkg::KIND_CLK_TICK: begin
                if (int'(shadow_prescale) + 1 >= COUNTER_DIVIDE) begin
                    shadow_prescale = '0;
                    shadow_counter  = shadow_counter + 1'b1;
                end else begin
                    shadow_prescale = shadow_prescale + 1'b1;
                end
            end
            sereg_pkg::KIND_PCM_DATA: begin
                shadow_latch = it.data;
                if (!shadow_pcm_ctl[sereg_pkg::MUTE_BIT]) begin
                    shadow_pcm_ticks = '0;
                    shadow_dac_due   = 1'b1;
                end
            end
            sereg_pkg::KIND_PCM_CTL: begin
                shadow_pcm_ctl = it.data[sereg_pkg::CTRL_W-1:0];
            end
            sereg_pkg::KIND_PCM_STAT: begin
                res.read_data = {it.comparator, 2'b00, shadow_pcm_ctl};
            end
            sereg_pkg::KIND_PCM_CNT: begin
                res.read_data = {6'b0, shadow_pcm_ticks};
            end
            sereg_pkg::KIND_PCM_TICK: begin
                shadow_pcm_ticks = shadow_pcm_ticks + 1'b1;
                if (shadow_dac_due) begin
                    res.dac_strobe = 1'b1;
                    res.dac_value  = shadow_latch;
                    shadow_dac_due = 1'b0;
                end
            end
            sereg_pkg::KIND_PAUSE_WR: begin
                shadow_leds    = {it.data[7], it.data[0]};
                shadow_halt_en = it.data[1];
            end
            sereg_pkg::KIND_PAUSE_BTN: begin
                if (shadow_halt_en &&
                    shadow_regs[sereg_pkg::CPU_REG][sereg_pkg::CPU_SEL_BIT]) begin
                    shadow_wait = it.pause_button;
                end
            end
            default: begin
            end
        endcase
        res.main_cpu_active = shadow_regs[sereg_pkg::CPU_REG][sereg_pkg::CPU_SEL_BIT];
        res.pcm_lines       = shadow_pcm_ctl;
        res.pause_led       = shadow_leds[0];
        res.turbo_led       = shadow_leds[1];
        res.cpu_wait        = shadow_wait;
    endtask

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item, wait for it to be taken, and record its prediction.
    task automatic send_item(input logic [3:0] kind_code, input logic [7:0] data,
                             input logic bsel, input logic fw, input logic comp,
                             input logic btn);
        sereg_pkg::item_t   it;
        sereg_pkg::result_t want;
        int                 gap;
        it.data            = data;
        it.byte_select     = bsel;
        it.firmware_switch = fw;
        it.comparator      = comp;
        it.pause_button    = btn;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it};
        s_tuser  <= kind_code;
        do @(posedge aclk); while (!s_tready);
        predict_engine_result(kind_code, it, want);
        engine_results_due.push_back(want);
        items_sent++;
    endtask

    // Offer an item whose side fields are random.
    task automatic send_kind(input logic [3:0] kind_code, input logic [7:0] data);
        send_item(kind_code, data, rbit(), rbit(), rbit(), rbit());
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (engine_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Index high bits, firmware switch readback and the CPU select entry.
    task automatic test_register_file();
        send_kind(sereg_pkg::KIND_IDX_WR, 8'hf5);
        send_kind(sereg_pkg::KIND_REG_WR, 8'haa);
        send_item(sereg_pkg::KIND_REG_RD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        send_item(sereg_pkg::KIND_REG_RD, 8'hff, 1'b1, 1'b0, 1'b1, 1'b1);
        send_kind(sereg_pkg::KIND_IDX_WR, {4'h0, sereg_pkg::CPU_REG});
        send_kind(sereg_pkg::KIND_REG_WR, 8'h00);
        drain_results();
    endtask

    // Memory writes shift into the two top entries.
    task automatic test_shift_registers();
        send_kind(sereg_pkg::KIND_MEM_WR, 8'h12);
        send_kind(sereg_pkg::KIND_MEM_WR, 8'hff);
        send_kind(sereg_pkg::KIND_IDX_WR, {4'hf, sereg_pkg::SHIFT_LO_REG});
        send_kind(sereg_pkg::KIND_REG_RD, 8'h00);
        drain_results();
    endtask

    // Counter reset and both byte reads.
    task automatic test_free_counter();
        send_kind(sereg_pkg::KIND_CLK_TICK, 8'h00);
        send_kind(sereg_pkg::KIND_CNT_RESET, 8'hff);
        send_item(sereg_pkg::KIND_CNT_RD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(sereg_pkg::KIND_CNT_RD, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        drain_results();
    endtask

    // Strobe timing, muted data writes and mute while a strobe is pending.
    task automatic test_pcm();
        send_kind(sereg_pkg::KIND_PCM_DATA, 8'h00);
        send_kind(sereg_pkg::KIND_PCM_CTL, 8'h02);
        send_kind(sereg_pkg::KIND_PCM_TICK, 8'h00);
        send_kind(sereg_pkg::KIND_PCM_DATA, 8'hff);
        send_kind(sereg_pkg::KIND_PCM_TICK, 8'h00);
        send_kind(sereg_pkg::KIND_PCM_CNT, 8'h00);
        send_kind(sereg_pkg::KIND_PCM_CTL, 8'hff);
        send_item(sereg_pkg::KIND_PCM_STAT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        drain_results();
    endtask

    // Pause LEDs, a button press with the second CPU active, and the spare kinds.
    task automatic test_pause();
        send_kind(sereg_pkg::KIND_PAUSE_WR, 8'h83);
        send_item(sereg_pkg::KIND_PAUSE_BTN, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        send_kind(KIND_SPARE_LO, 8'hff);
        send_kind(KIND_SPARE_HI, 8'hff);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        gaps_on     = 1'b0;
        ready_style = READY_ALWAYS;
        hold_requests++;
        repeat (40) send_kind(4'($urandom_range(0, 15)), 8'($urandom));
        drain_results();
        gaps_on     = 1'b1;
        ready_style = READY_PATTERN;
    endtask

    // Random traffic built mostly from well-formed access sequences.
    task automatic test_random_traffic();
        int         scenario;
        int         reps;
        logic [7:0] val;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 31) == 0) begin
                gaps_on     = ($urandom_range(0, 3) != 0);
                ready_style = $urandom_range(READY_ALWAYS, READY_PATTERN);
            end
            scenario = $urandom_range(0, 7);
            val      = 8'($urandom);
            case (scenario)
                0: begin
                    send_kind(sereg_pkg::KIND_IDX_WR, val);
                    send_kind(sereg_pkg::KIND_REG_WR, 8'($urandom));
                    send_kind(sereg_pkg::KIND_REG_RD, 8'($urandom));
                end
                1: begin
                    send_kind(sereg_pkg::KIND_IDX_WR, val);
                    repeat ($urandom_range(1, 3))
                        send_kind(sereg_pkg::KIND_REG_RD, 8'($urandom));
                end
                2: begin
                    repeat ($urandom_range(1, 3))
                        send_kind(sereg_pkg::KIND_MEM_WR, 8'($urandom));
                    send_kind(sereg_pkg::KIND_IDX_WR, {val[7:4], 3'b111, val[0]});
                    if ($urandom_range(0, 3) == 0) begin
                        send_kind(sereg_pkg::KIND_REG_WR, 8'($urandom));
                    end
                    send_kind(sereg_pkg::KIND_REG_RD, 8'($urandom));
                end
                3: begin
                    // Write a random CPU select, then try the pause button.
                    send_kind(sereg_pkg::KIND_IDX_WR, {val[7:4], sereg_pkg::CPU_REG});
                    send_kind(sereg_pkg::KIND_REG_WR, 8'($urandom));
                    send_kind(sereg_pkg::KIND_PAUSE_WR, 8'($urandom));
                    repeat ($urandom_range(1, 3))
                        send_kind(sereg_pkg::KIND_PAUSE_BTN, 8'($urandom));
                end
                4: begin
                    send_kind(sereg_pkg::KIND_PAUSE_WR, val);
                    repeat ($urandom_range(1, 4))
                        send_kind(sereg_pkg::KIND_PAUSE_BTN, 8'($urandom));
                end
                5: begin
                    if (rbit()) begin
                        send_kind(sereg_pkg::KIND_PCM_CTL, 8'($urandom));
                    end
                    send_kind(sereg_pkg::KIND_PCM_DATA, val);
                    reps = $urandom_range(0, 3);
                    repeat (reps) send_kind(sereg_pkg::KIND_PCM_TICK, 8'($urandom));
                    send_kind(sereg_pkg::KIND_PCM_CNT, 8'($urandom));
                    if (rbit()) begin
                        send_kind(sereg_pkg::KIND_PCM_STAT, 8'($urandom));
                    end
                end
                6: begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_kind(sereg_pkg::KIND_CNT_RESET, val);
                    end
                    repeat ($urandom_range(1, 40))
                        send_kind(sereg_pkg::KIND_CLK_TICK, 8'($urandom));
                    send_item(sereg_pkg::KIND_CNT_RD, 8'($urandom), 1'b0,
                              rbit(), rbit(), rbit());
                    send_item(sereg_pkg::KIND_CNT_RD, 8'($urandom), 1'b1,
                              rbit(), rbit(), rbit());
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        send_kind(4'($urandom_range(0, 15)), 8'($urandom));
                end
            endcase
        end
        drain_results();
    endtask

    // Receiver ready: long hold-offs on request, otherwise the current stall style.
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD_CYCLES;
        end
        if (pattern_pos == 0) begin
            ready_pattern = 16'($urandom) | 16'h0101;
        end
        pattern_pos = (pattern_pos + 1) % 16;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:      m_tready <= ready_pattern[pattern_pos];
            endcase
        end
    end

    task automatic compare_field(input string field_name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = sereg_pkg::result_t'(m_tdata[$bits(sereg_pkg::result_t)-1:0]);
            if (engine_results_due.size() == 0) begin
                $display("%0t: result item with none expected, expected none, actual 0x%0h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want_result = engine_results_due.pop_front();
                compare_field("read_data", want_result.read_data, got_result.read_data);
                compare_field("main_cpu_active", want_result.main_cpu_active,
                              got_result.main_cpu_active);
                compare_field("dac_strobe", want_result.dac_strobe, got_result.dac_strobe);
                compare_field("dac_value", want_result.dac_value, got_result.dac_value);
                compare_field("pcm_lines", want_result.pcm_lines, got_result.pcm_lines);
                compare_field("pause_led", want_result.pause_led, got_result.pause_led);
                compare_field("turbo_led", want_result.turbo_led, got_result.turbo_led);
                compare_field("cpu_wait", want_result.cpu_wait, got_result.cpu_wait);
                compare_field("padding", 8'h00, m_tdata[31:$bits(sereg_pkg::result_t)]);
            end
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        reset_engine_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_file();
        test_shift_registers();
        test_free_counter();
        test_pcm();
        test_pause();
        test_backpressure();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
